[design/assert_macros.svh]
// Assertion macros for the stack core RTL, included by the request sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define PVS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define PVS_ASSERT_NEXT(name, ante, cons, msg) \
   `PVS_ASSERT(name, ((ante) |=> (cons)), msg)

`endif

[design/pvs_pkg.sv]
// Types and constants for the positional value stack core
`default_nettype none

package pvs_pkg;

   localparam int OP_W        = 3;
   localparam int WORD_W      = 64;
   localparam int POS_W       = 10;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 11;
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 80;

   localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
   localparam logic [OP_W-1:0] OP_POP     = 3'd1;
   localparam logic [OP_W-1:0] OP_DUP_ADJ = 3'd2;
   localparam logic [OP_W-1:0] OP_DUP_TOP = 3'd3;
   localparam logic [OP_W-1:0] OP_SWAP    = 3'd4;
   localparam logic [OP_W-1:0] OP_DELETE  = 3'd5;
   localparam logic [OP_W-1:0] OP_PEEK    = 3'd6;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd7;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [WORD_W-1:0] word;
      logic [POS_W-1:0]  pos_a;
      logic [POS_W-1:0]  pos_b;
   } req_item_type;

   typedef struct packed {
      logic [COUNT_OUT_W-1:0] entry_count;
      logic [STATUS_W-1:0]    status;
      logic [WORD_W-1:0]      read_word;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } done_type;

endpackage

`default_nettype wire

[design/positional_value_stack_core.sv]
// Top level of the positional value stack core
// Stack of 64-bit words with push, pop, peek, swap, positional duplicate and delete, clear.
// Requests arrive on req_; each produces exactly one response transaction on rsp_.
// Position 0 is the bottom entry; positions at or beyond the entry count are rejected.
// One request is in flight at a time; req_tready is high while the sequencer is idle.
// Sequencing from request acceptance to the done state:
//   push, clear, any rejected request: straight to done
//   pop, peek: RAM read, then read-data capture; duplicate onto top: read, then write
//   swap: read of both entries, then write of both
//   duplicate adjacent / delete: a shift that moves count - pos, or count - pos - 1,
//   entries, one entry per cycle through the single RAM read/write pair, each read
//   one entry ahead of its write-back.
// The next request is taken the cycle after the response enters the output register.
// A stalled rsp_tready holds the response; one more request may complete behind it
// and then waits in the sequencer until the output register frees.
// Reset (synchronous) empties the stack; RAM contents are not cleared and need no sweep.
`default_nettype none

module positional_value_stack_core #(
   parameter int STACK_DEPTH = 1024
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // push_word [63:0], first_pos [73:64], second_pos [83:74], zero pad
   input  wire logic [pvs_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type [2:0]
   input  wire logic [pvs_pkg::OP_W-1:0]        req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // read_word [63:0], status [65:64], entry_count [76:66], zero pad
   output logic [pvs_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);

   import pvs_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   req_item_type      req;
   done_type          done;
   logic              rsp_free;
   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   assign req.op    = req_tuser;
   assign req.word  = req_tdata[WORD_W-1:0];
   assign req.pos_a = req_tdata[WORD_W +: POS_W];
   assign req.pos_b = req_tdata[WORD_W + POS_W +: POS_W];

   pvs_ctrl #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .done      (done),
      .rsp_free  (rsp_free),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   pvs_ram #(
      .WIDTH(WORD_W),
      .DEPTH(STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = (done.valid && rsp_free) || (rsp_valid_ff && !rsp_tready);
   assign rsp_item_in  = (done.valid && rsp_free) ? done.item : rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_item_ff);

endmodule

`default_nettype wire

[design/pvs_ram.sv]
// Generic simple dual-port RAM, one write port and one registered read port
`default_nettype none

module pvs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[design/pvs_ctrl.sv]
// Request sequencer: decodes each transaction and drives the stack RAM
`default_nettype none
`include "assert_macros.svh"

module pvs_ctrl #(
   parameter int STACK_DEPTH = 1024,
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
   localparam int CW = $clog2(STACK_DEPTH + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire pvs_pkg::req_item_type req,
   output pvs_pkg::done_type          done,
   input  wire logic                  rsp_free,
   output logic                       ram_we,
   output logic [AW-1:0]              ram_waddr,
   output logic [pvs_pkg::WORD_W-1:0] ram_wdata,
   output logic                       ram_re,
   output logic [AW-1:0]              ram_raddr,
   input  wire logic [pvs_pkg::WORD_W-1:0] ram_rdata
);

   import pvs_pkg::*;

   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RDWAIT = 3'd1;
   localparam logic [2:0] S_DUPW   = 3'd2;
   localparam logic [2:0] S_SWB    = 3'd3;
   localparam logic [2:0] S_SWW1   = 3'd4;
   localparam logic [2:0] S_SWW2   = 3'd5;
   localparam logic [2:0] S_SHIFT  = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       remain_ff, remain_in;
   logic [AW-1:0]       pa_ff, pa_in;
   logic [AW-1:0]       pb_ff, pb_in;
   logic [AW-1:0]       src_ff, src_in;
   logic [AW-1:0]       dst_ff, dst_in;
   logic                pend_ff, pend_in;
   logic                down_ff, down_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [WORD_W-1:0]   hold_ff, hold_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic                accept;
   logic                range_a, range_b, full, empty;
   logic [STATUS_W-1:0] status_c;
   logic [AW-1:0]       pa_addr, top_addr, cnt_addr;

   assign accept   = (state_ff == S_IDLE) && req_valid;
   assign range_a  = CMPW'(req.pos_a) >= CMPW'(count_ff);
   assign range_b  = CMPW'(req.pos_b) >= CMPW'(count_ff);
   assign full     = count_ff == CW'(STACK_DEPTH);
   assign empty    = count_ff == '0;
   assign pa_addr  = AW'(req.pos_a);
   assign top_addr = AW'(count_ff - CW'(1));
   assign cnt_addr = AW'(count_ff);

   always_comb begin
      status_c = ST_OK;
      unique case (req.op) inside
         OP_PUSH: begin
            if (full) status_c = ST_FULL;
         end
         OP_POP: begin
            if (empty) status_c = ST_EMPTY;
         end
         OP_DUP_ADJ, OP_DUP_TOP: begin
            if (range_a)   status_c = ST_RANGE;
            else if (full) status_c = ST_FULL;
         end
         OP_SWAP: begin
            if (range_a || range_b) status_c = ST_RANGE;
         end
         OP_DELETE, OP_PEEK: begin
            if (range_a) status_c = ST_RANGE;
         end
         default: status_c = ST_OK;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      remain_in = remain_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      pend_in   = pend_ff;
      down_in   = down_ff;
      word_in   = word_ff;
      hold_in   = hold_ff;
      status_in = status_ff;
      ram_we    = 1'b0;
      ram_waddr = dst_ff;
      ram_wdata = ram_rdata;
      ram_re    = 1'b0;
      ram_raddr = src_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               word_in   = '0;
               status_in = status_c;
               pa_in     = pa_addr;
               pb_in     = AW'(req.pos_b);
               pend_in   = 1'b0;
               if (status_c != ST_OK) begin
                  state_in = S_DONE;
               end else begin
                  unique case (req.op)
                     OP_PUSH: begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_addr;
                        ram_wdata = req.word;
                        count_in  = count_ff + CW'(1);
                        state_in  = S_DONE;
                     end
                     OP_POP: begin
                        ram_re    = 1'b1;
                        ram_raddr = top_addr;
                        count_in  = count_ff - CW'(1);
                        state_in  = S_RDWAIT;
                     end
                     OP_PEEK: begin
                        ram_re    = 1'b1;
                        ram_raddr = pa_addr;
                        state_in  = S_RDWAIT;
                     end
                     OP_DUP_TOP: begin
                        ram_re    = 1'b1;
                        ram_raddr = pa_addr;
                        dst_in    = cnt_addr;
                        count_in  = count_ff + CW'(1);
                        state_in  = S_DUPW;
                     end
                     OP_SWAP: begin
                        ram_re    = 1'b1;
                        ram_raddr = pa_addr;
                        state_in  = S_SWB;
                     end
                     OP_DUP_ADJ: begin
                        src_in    = top_addr;
                        remain_in = count_ff - CW'(req.pos_a);
                        down_in   = 1'b1;
                        count_in  = count_ff + CW'(1);
                        state_in  = S_SHIFT;
                     end
                     OP_DELETE: begin
                        src_in    = pa_addr + AW'(1);
                        remain_in = count_ff - CW'(req.pos_a) - CW'(1);
                        down_in   = 1'b0;
                        count_in  = count_ff - CW'(1);
                        state_in  = S_SHIFT;
                     end
                     OP_CLEAR: begin
                        count_in = '0;
                        state_in = S_DONE;
                     end
                     default: state_in = S_DONE;
                  endcase
               end
            end
         end
         S_RDWAIT: begin
            word_in  = ram_rdata;
            state_in = S_DONE;
         end
         S_DUPW: begin
            ram_we    = 1'b1;
            ram_waddr = dst_ff;
            state_in  = S_DONE;
         end
         S_SWB: begin
            ram_re    = 1'b1;
            ram_raddr = pb_ff;
            hold_in   = ram_rdata;
            state_in  = S_SWW1;
         end
         S_SWW1: begin
            ram_we    = 1'b1;
            ram_waddr = pa_ff;
            state_in  = S_SWW2;
         end
         S_SWW2: begin
            ram_we    = 1'b1;
            ram_waddr = pb_ff;
            ram_wdata = hold_ff;
            state_in  = S_DONE;
         end
         S_SHIFT: begin
            // read runs one entry ahead of the write-back
            ram_we    = pend_ff;
            ram_waddr = dst_ff;
            if (remain_ff != '0) begin
               ram_re    = 1'b1;
               ram_raddr = src_ff;
               src_in    = down_ff ? src_ff - AW'(1) : src_ff + AW'(1);
               dst_in    = down_ff ? src_ff + AW'(1) : src_ff - AW'(1);
               remain_in = remain_ff - CW'(1);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      pa_ff     <= pa_in;
      pb_ff     <= pb_in;
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      down_ff   <= down_in;
      word_ff   <= word_in;
      hold_ff   <= hold_in;
      status_ff <= status_in;
   end

   assign req_ready             = state_ff == S_IDLE;
   assign done.valid            = state_ff == S_DONE;
   assign done.item.read_word   = word_ff;
   assign done.item.status      = status_ff;
   assign done.item.entry_count = COUNT_OUT_W'(count_ff);

   `PVS_ASSERT(a_no_rw_collision, ((ram_we && ram_re) |-> (ram_waddr != ram_raddr)), "read and write hit the same entry")
   `PVS_ASSERT_NEXT(a_push_count, (accept && req.op == OP_PUSH && !full), (count_ff == $past(count_ff) + CW'(1)), "push did not grow the stack")
   `PVS_ASSERT_NEXT(a_done_holds, (state_ff == S_DONE && !rsp_free), (state_ff == S_DONE), "result left before it was taken")
   `PVS_ASSERT_NEXT(a_shift_ends, (state_ff == S_SHIFT && remain_ff == '0 && !pend_ff), (state_ff == S_DONE), "shift did not finish")

endmodule

`default_nettype wire
